/* src/rpt_pkg.sv */
// Shared types, constants and lexing functions for the regex pattern tokenizer.
package rpt_pkg;

  localparam int NAME_MAX   = 32;
  localparam int GROUP_BITS = 16;
  localparam int POS_BITS   = 16;

  localparam int NCNT_W      = $clog2(NAME_MAX + 1);
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [GROUP_BITS-1:0] grp_t;
  typedef logic [NCNT_W-1:0]     ncnt_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [FCNT_W-1:0]     fcnt_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_G      = 8'h67;

  localparam logic [2:0] CLS_ANY   = 3'd0;
  localparam logic [2:0] CLS_SPACE = 3'd1;
  localparam logic [2:0] CLS_DIGIT = 3'd2;
  localparam logic [2:0] CLS_WORD  = 3'd3;
  localparam logic [2:0] CLS_START = 3'd4;
  localparam logic [2:0] CLS_END   = 3'd5;

  typedef enum logic [4:0] {
    TK_RANGE, TK_MATCH, TK_BACKREF_NUM, TK_BACKREF_NAME, TK_LAZY_STAR, TK_STAR,
    TK_LAZY_PLUS, TK_PLUS, TK_OPTIONAL, TK_NONCAP_OPEN, TK_NAMED_OPEN, TK_GROUP_OPEN,
    TK_GROUP_CLOSE, TK_CLASS_OPEN_INV, TK_CLASS_OPEN, TK_CLASS_CLOSE, TK_ALT,
    TK_NAME_CHAR, TK_ERROR, TK_DONE
  } tok_kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_HELD, MODE_RANGE, MODE_NUM, MODE_PQ, MODE_COMMENT, MODE_NAMED,
    MODE_GBRACE, MODE_GFIRST, MODE_GNUM, MODE_GNAME, MODE_SKIP
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_char;
    logic       in_class;
    grp_t       number_acc;
    ncnt_t      name_count;
    logic       error_seen;
    pos_t       mark_pos;
    logic       num_bad;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    mode: MODE_IDLE, held_char: 8'h00, in_class: 1'b0, number_acc: '0,
    name_count: '0, error_seen: 1'b0, mark_pos: '0, num_bad: 1'b0
  };

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  char_value;
    logic [7:0]  range_upper;
    logic        is_class;
    logic [2:0]  special_class;
    logic        inverted;
    logic [15:0] group_number;
    logic [5:0]  name_length;
    logic [15:0] position;
    logic        run_last;
  } res_t;

  typedef struct packed {
    lex_state_t st;
    logic       hit;
    res_t       tok;
  } feed_t;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       end_flag;
  } lex_in_t;

  typedef struct packed {
    logic [1:0]                 count;
    res_t [MAX_RESULTS-1:0]     res;
  } step_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic grp_t mul10_add(grp_t a, logic [3:0] d);
    return (a << 3) + (a << 1) + grp_t'(d);
  endfunction

  function automatic res_t tok_make(tok_kind_t k, pos_t p);
    res_t r;
    r = '0;
    r.kind = k;
    r.position = 16'(p);
    return r;
  endfunction

  function automatic res_t lit_tok(logic [7:0] c, pos_t p);
    res_t r;
    r = tok_make(TK_MATCH, p);
    r.char_value = c;
    return r;
  endfunction

  function automatic res_t class_tok(logic [2:0] cls, logic inv, pos_t p);
    res_t r;
    r = tok_make(TK_MATCH, p);
    r.is_class = 1'b1;
    r.special_class = cls;
    r.inverted = inv;
    return r;
  endfunction

  function automatic res_t escape_tok(logic [7:0] c, pos_t p);
    res_t r;
    case (c)
      "t": r = lit_tok(8'd9, p);
      "r": r = lit_tok(8'd13, p);
      "n": r = lit_tok(8'd10, p);
      "f": r = lit_tok(8'd12, p);
      "S": r = class_tok(CLS_SPACE, 1'b1, p);
      "s": r = class_tok(CLS_SPACE, 1'b0, p);
      "D": r = class_tok(CLS_DIGIT, 1'b1, p);
      "d": r = class_tok(CLS_DIGIT, 1'b0, p);
      "W": r = class_tok(CLS_WORD, 1'b1, p);
      "w": r = class_tok(CLS_WORD, 1'b0, p);
      default: r = lit_tok(c, p);
    endcase
    return r;
  endfunction

  function automatic res_t num_tok(grp_t g, pos_t p);
    res_t r;
    r = tok_make(TK_BACKREF_NUM, p);
    r.group_number = 16'(g);
    return r;
  endfunction

  function automatic res_t named_tok(tok_kind_t k, ncnt_t n, pos_t p);
    res_t r;
    r = tok_make(k, p);
    r.name_length = 6'(n);
    return r;
  endfunction

  function automatic feed_t emit(feed_t f, res_t r);
    feed_t g;
    g = f;
    g.hit = 1'b1;
    g.tok = r;
    return g;
  endfunction

  function automatic feed_t fail(feed_t f, pos_t p);
    feed_t g;
    g = emit(f, tok_make(TK_ERROR, p));
    g.st.error_seen = 1'b1;
    g.st.mode = MODE_SKIP;
    return g;
  endfunction

  function automatic lex_state_t start_tok(lex_state_t s, logic [7:0] c);
    lex_state_t t;
    t = s;
    if (c == CH_NUL) begin
      t.mode = MODE_IDLE;
    end else begin
      t.held_char = c;
      t.mode = MODE_HELD;
    end
    return t;
  endfunction

  function automatic feed_t name_add(feed_t f, logic [7:0] c, pos_t p1);
    feed_t g;
    res_t r;
    g = f;
    if (f.st.name_count < ncnt_t'(NAME_MAX)) begin
      g.st.name_count = f.st.name_count + ncnt_t'(1);
      r = named_tok(TK_NAME_CHAR, g.st.name_count, p1);
      r.char_value = c;
      g = emit(g, r);
    end
    return g;
  endfunction

  // One byte of lexing: next state and at most one token.
  function automatic feed_t feed(lex_state_t s, logic [7:0] c, pos_t pos);
    feed_t      f;
    pos_t       pos1;
    logic [7:0] h;
    f.st = s;
    f.hit = 1'b0;
    f.tok = '0;
    pos1 = pos + pos_t'(1);
    h = s.held_char;
    case (s.mode)
      MODE_IDLE: f.st = start_tok(s, c);
      MODE_HELD: begin
        if (c == CH_DASH) begin
          f.st.mode = MODE_RANGE;
        end else if (h == CH_BSLASH) begin
          if (c == CH_NUL) begin
            f = fail(f, pos);
          end else if (is_dig(c)) begin
            f.st.number_acc = grp_t'(c[3:0]);
            f.st.mode = MODE_NUM;
          end else if (c == CH_G && !s.in_class) begin
            f.st.mode = MODE_GBRACE;
          end else begin
            f = emit(f, escape_tok(c, pos1));
            f.st.mode = MODE_IDLE;
          end
        end else if (!s.in_class && h == CH_DOT) begin
          f = emit(f, class_tok(CLS_ANY, 1'b0, pos));
          f.st = start_tok(f.st, c);
        end else if (!s.in_class && (h == CH_STAR || h == CH_PLUS)) begin
          if (c == CH_QMARK) begin
            f = emit(f, tok_make((h == CH_STAR) ? TK_LAZY_STAR : TK_LAZY_PLUS, pos1));
            f.st.mode = MODE_IDLE;
          end else begin
            f = emit(f, tok_make((h == CH_STAR) ? TK_STAR : TK_PLUS, pos));
            f.st = start_tok(f.st, c);
          end
        end else if (!s.in_class && h == CH_QMARK) begin
          f = emit(f, tok_make(TK_OPTIONAL, pos));
          f.st = start_tok(f.st, c);
        end else if (!s.in_class && h == CH_LPAREN) begin
          if (c == CH_QMARK) begin
            f.st.mode = MODE_PQ;
          end else begin
            f = emit(f, tok_make(TK_GROUP_OPEN, pos));
            f.st = start_tok(f.st, c);
          end
        end else if (!s.in_class && h == CH_RPAREN) begin
          f = emit(f, tok_make(TK_GROUP_CLOSE, pos));
          f.st = start_tok(f.st, c);
        end else if (!s.in_class && h == CH_LBRACK) begin
          f.st.in_class = 1'b1;
          if (c == CH_CARET) begin
            f = emit(f, tok_make(TK_CLASS_OPEN_INV, pos1));
            f.st.mode = MODE_IDLE;
          end else begin
            f = emit(f, tok_make(TK_CLASS_OPEN, pos));
            f.st = start_tok(f.st, c);
          end
        end else if (!s.in_class && h == CH_BAR) begin
          f = emit(f, tok_make(TK_ALT, pos));
          f.st = start_tok(f.st, c);
        end else if (!s.in_class && h == CH_CARET) begin
          f = emit(f, class_tok(CLS_START, 1'b0, pos));
          f.st = start_tok(f.st, c);
        end else if (!s.in_class && h == CH_DOLLAR) begin
          f = emit(f, class_tok(CLS_END, 1'b0, pos));
          f.st = start_tok(f.st, c);
        end else if (h == CH_RBRACK) begin
          f = emit(f, tok_make(TK_CLASS_CLOSE, pos));
          f.st.in_class = 1'b0;
          f.st = start_tok(f.st, c);
        end else begin
          f = emit(f, lit_tok(h, pos));
          f.st = start_tok(f.st, c);
        end
      end
      MODE_RANGE: begin
        if (c == CH_NUL) begin
          f = fail(f, pos);
        end else begin
          f.tok = tok_make(TK_RANGE, pos1);
          f.tok.char_value = h;
          f.tok.range_upper = c;
          f.hit = 1'b1;
          f.st.mode = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_dig(c)) begin
          f.st.number_acc = mul10_add(s.number_acc, c[3:0]);
        end else begin
          if (s.in_class) begin
            f = emit(f, lit_tok(s.number_acc[7:0], pos));
          end else begin
            f = emit(f, num_tok(s.number_acc, pos));
          end
          f.st = start_tok(f.st, c);
        end
      end
      MODE_PQ: begin
        if (c == CH_COLON) begin
          f = emit(f, tok_make(TK_NONCAP_OPEN, pos1));
          f.st.mode = MODE_IDLE;
        end else if (c == CH_HASH) begin
          f.st.mode = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
          f.st.name_count = '0;
          f.st.mode = MODE_NAMED;
        end else if (c == CH_NUL) begin
          f.st.mode = MODE_IDLE;
        end else begin
          f = fail(f, pos);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_RPAREN || c == CH_NUL) begin
          f.st.mode = MODE_IDLE;
        end
      end
      MODE_NAMED: begin
        if (c == CH_QUOTE) begin
          if (s.name_count >= ncnt_t'(NAME_MAX)) begin
            f = fail(f, pos1);
          end else begin
            f = emit(f, named_tok(TK_NAMED_OPEN, s.name_count, pos1));
            f.st.mode = MODE_IDLE;
          end
        end else if (c == CH_NUL) begin
          f.st.mode = MODE_IDLE;
        end else begin
          f = name_add(f, c, pos1);
        end
      end
      MODE_GBRACE: begin
        if (c == CH_LBRACE) begin
          f.st.mode = MODE_GFIRST;
        end else if (c == CH_NUL) begin
          f.st.mode = MODE_IDLE;
        end else begin
          f = fail(f, pos);
        end
      end
      MODE_GFIRST: begin
        if (c == CH_NUL) begin
          f.st.mode = MODE_IDLE;
        end else if (c == CH_PLUS || c == CH_DASH) begin
          f = fail(f, pos);
        end else if (c == CH_RBRACE) begin
          f = emit(f, tok_make(TK_BACKREF_NAME, pos1));
          f.st.mode = MODE_IDLE;
        end else if (is_dig(c)) begin
          f.st.mark_pos = pos;
          f.st.number_acc = grp_t'(c[3:0]);
          f.st.num_bad = 1'b0;
          f.st.mode = MODE_GNUM;
        end else begin
          f.st.mark_pos = pos;
          f.st.name_count = '0;
          f.st.mode = MODE_GNAME;
          f = name_add(f, c, pos1);
        end
      end
      MODE_GNUM: begin
        if (c == CH_NUL) begin
          f = fail(f, s.mark_pos);
        end else if (c == CH_RBRACE) begin
          if (s.num_bad) begin
            f = fail(f, pos1);
          end else begin
            f = emit(f, num_tok(s.number_acc, pos1));
            f.st.mode = MODE_IDLE;
          end
        end else if (is_dig(c) && !s.num_bad) begin
          f.st.number_acc = mul10_add(s.number_acc, c[3:0]);
        end else begin
          f.st.num_bad = 1'b1;
        end
      end
      MODE_GNAME: begin
        if (c == CH_NUL) begin
          f = fail(f, s.mark_pos);
        end else if (c == CH_RBRACE) begin
          if (s.name_count >= ncnt_t'(NAME_MAX)) begin
            f = fail(f, pos1);
          end else begin
            f = emit(f, named_tok(TK_BACKREF_NAME, s.name_count, pos1));
            f.st.mode = MODE_IDLE;
          end
        end else begin
          f = name_add(f, c, pos1);
        end
      end
      default: f.st = s;
    endcase
    return f;
  endfunction

endpackage

/* src/rpt_pattern_if.sv */
// Pattern byte channel: valid/ready handshake with byte and end flag.
interface rpt_pattern_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_byte;
  logic       end_flag;

  modport source (output valid, output pattern_byte, output end_flag, input ready);
  modport sink (input valid, input pattern_byte, input end_flag, output ready);
endinterface

/* src/rpt_token_if.sv */
// Token channel: valid/ready handshake with the token fields.
interface rpt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [7:0]  char_value;
  logic [7:0]  range_upper;
  logic        is_class;
  logic [2:0]  special_class;
  logic        inverted;
  logic [15:0] group_number;
  logic [5:0]  name_length;
  logic [15:0] position;
  logic        run_last;

  modport source (
    output valid, output token_kind, output char_value, output range_upper,
    output is_class, output special_class, output inverted, output group_number,
    output name_length, output position, output run_last, input ready
  );
  modport sink (
    input valid, input token_kind, input char_value, input range_upper,
    input is_class, input special_class, input inverted, input group_number,
    input name_length, input position, input run_last, output ready
  );
endinterface

/* src/regex_pattern_tokenizer.sv */
// Streaming regex lexer: one pattern byte per cycle in when ready, tokens out via a queue.
// The tokenizer accepts one pattern byte per clock and lexes it in the same cycle with a
// one-byte lookahead, writing the tokens it completes into a four-entry result queue that
// delivers one token per clock while the receiver is ready. With the receiver ready, a
// byte that completes at most one token sustains one byte per cycle; the final byte of a
// pattern (end flag set, or a zero byte) can produce up to three tokens, ending with done,
// and the input then waits while the queue drains. Input is taken whenever reset is low
// and the queue holds at most one token, so one waiting token does not block the next
// byte, while two or more do.
module regex_pattern_tokenizer (
  input  logic        clk,
  input  logic        rst,
  rpt_pattern_if.sink pattern,
  rpt_token_if.source tokens
);

  rpt_pkg::lex_in_t item;
  rpt_pkg::step_t   step;
  rpt_pkg::res_t    head;
  logic             room, advance, head_valid;

  assign item.pattern_byte = pattern.pattern_byte;
  assign item.end_flag     = pattern.end_flag;
  assign pattern.ready     = room && !rst;
  assign advance           = pattern.valid && room;

  rpt_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .step    (step)
  );

  rpt_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_en    (advance),
    .step       (step),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (tokens.ready)
  );

  assign tokens.valid         = head_valid;
  assign tokens.token_kind    = head.kind;
  assign tokens.char_value    = head.char_value;
  assign tokens.range_upper   = head.range_upper;
  assign tokens.is_class      = head.is_class;
  assign tokens.special_class = head.special_class;
  assign tokens.inverted      = head.inverted;
  assign tokens.group_number  = head.group_number;
  assign tokens.name_length   = head.name_length;
  assign tokens.position      = head.position;
  assign tokens.run_last      = head.run_last;

endmodule

/* src/rpt_lexer.sv */
// Lexer state registers and the per-byte step that yields up to three tokens.
module rpt_lexer (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rpt_pkg::lex_in_t item,
  output rpt_pkg::step_t   step
);

  rpt_pkg::lex_state_t state, state_next;
  rpt_pkg::pos_t       byte_position, byte_position_next;

  rpt_pkg::feed_t f1, f2;
  rpt_pkg::pos_t  pos_after;
  rpt_pkg::res_t  done_tok;
  logic           has_byte, is_end, hit1, hit2;

  always_comb begin
    has_byte = item.pattern_byte != rpt_pkg::CH_NUL;
    is_end   = item.end_flag || !has_byte;

    f1 = '{st: state, hit: 1'b0, tok: '0};
    if (has_byte && !state.error_seen) begin
      f1 = rpt_pkg::feed(state, item.pattern_byte, byte_position);
    end
    pos_after = has_byte ? byte_position + rpt_pkg::pos_t'(1) : byte_position;

    f2 = '{st: f1.st, hit: 1'b0, tok: '0};
    if (is_end && !f1.st.error_seen) begin
      f2 = rpt_pkg::feed(f1.st, rpt_pkg::CH_NUL, pos_after);
    end
    done_tok = rpt_pkg::tok_make(rpt_pkg::TK_DONE, pos_after);

    hit1 = f1.hit;
    hit2 = is_end && f2.hit;

    step.count  = {1'b0, hit1} + {1'b0, hit2} + {1'b0, is_end};
    step.res[0] = hit1 ? f1.tok : (hit2 ? f2.tok : done_tok);
    step.res[1] = (hit1 && hit2) ? f2.tok : done_tok;
    step.res[2] = done_tok;
    for (int i = 0; i < rpt_pkg::MAX_RESULTS; i++) begin
      step.res[i].run_last = (2'(i) == step.count - 2'd1);
    end

    state_next         = is_end ? rpt_pkg::LEX_RESET : f1.st;
    byte_position_next = is_end ? '0 : pos_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rpt_pkg::LEX_RESET;
      byte_position <= '0;
    end else if (advance) begin
      state         <= state_next;
      byte_position <= byte_position_next;
    end
  end

endmodule

/* src/rpt_result_fifo.sv */
// Result queue: takes up to three tokens per transaction, delivers one per cycle when popped.
module rpt_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_en,
  input  rpt_pkg::step_t step,
  output logic           room,
  output logic           head_valid,
  output rpt_pkg::res_t  head,
  input  logic           pop
);

  rpt_pkg::res_t  mem [rpt_pkg::FIFO_DEPTH];
  rpt_pkg::ptr_t  wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  rpt_pkg::fcnt_t count, count_next;
  logic [1:0]     push_n;
  logic           pop_n;

  always_comb begin
    push_n      = push_en ? step.count : 2'd0;
    pop_n       = pop && head_valid;
    wr_ptr_next = wr_ptr + rpt_pkg::ptr_t'(push_n);
    rd_ptr_next = rd_ptr + rpt_pkg::ptr_t'(pop_n);
    count_next  = count + rpt_pkg::fcnt_t'(push_n) - rpt_pkg::fcnt_t'(pop_n);
  end

  assign room       = count <= rpt_pkg::fcnt_t'(rpt_pkg::FIFO_DEPTH - rpt_pkg::MAX_RESULTS);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rpt_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push_n) begin
        mem[wr_ptr + rpt_pkg::ptr_t'(i)] <= step.res[i];
      end
    end
  end

endmodule

/* src/rpt_checker.sv */
// Port-level assertions for the tokenizer and the bind that attaches them.
module rpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [4:0]  token_kind,
  input logic [7:0]  char_value,
  input logic [7:0]  range_upper,
  input logic        run_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(token_kind) && $stable(char_value)
      && $stable(run_last))
    else $error("token changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind == rpt_pkg::TK_DONE |-> run_last)
    else $error("done token not marked last");

  a_range_upper: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind != rpt_pkg::TK_RANGE |-> range_upper == 8'h00)
    else $error("upper bound set on a non-range token");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("token offered right after reset");

endmodule

bind regex_pattern_tokenizer rpt_checker u_rpt_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (tokens.valid),
  .ready       (tokens.ready),
  .token_kind  (tokens.token_kind),
  .char_value  (tokens.char_value),
  .range_upper (tokens.range_upper),
  .run_last    (tokens.run_last)
);
